// ----- hw/rtl/swpf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swpf_pkg
// shared types and constants of the servo write packet framer
// ----------------------------------------------------------------------------
package swpf_pkg;

   // command codes
   localparam logic [2:0] OP_LED    = 3'd0;
   localparam logic [2:0] OP_WHEEL  = 3'd1;
   localparam logic [2:0] OP_LIMITS = 3'd2;
   localparam logic [2:0] OP_GOAL   = 3'd3;
   localparam logic [2:0] OP_TORQUE = 3'd4;

   // configuration register indexes
   localparam logic CSR_JOINT_CW  = 1'b0;
   localparam logic CSR_JOINT_CCW = 1'b1;

   localparam int unsigned LIMIT_W = 10;
   localparam logic [LIMIT_W-1:0] JOINT_CW_RESET  = 10'd0;
   localparam logic [LIMIT_W-1:0] JOINT_CCW_RESET = 10'd1023;

   // frame bytes
   localparam logic [7:0] SYNC_BYTE    = 8'hFF;
   localparam logic [7:0] INSTR_WRITE  = 8'h03;
   localparam logic [7:0] ADDR_LIMITS  = 8'h06;
   localparam logic [7:0] ADDR_TORQUE  = 8'h18;
   localparam logic [7:0] ADDR_LED     = 8'h19;
   localparam logic [7:0] ADDR_GOAL    = 8'h1E;
   localparam logic [7:0] ADDR_SPEED   = 8'h20;
   localparam logic [7:0] LEN_OVERHEAD = 8'h03;

   // byte offset of the second frame within a command
   localparam logic [4:0] FRAME1_START = 5'd11;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  servo_id;
      logic [7:0]  byte_value;
      logic [15:0] speed_word;
      logic [15:0] position_word;
      logic [15:0] cw_limit;
      logic [15:0] ccw_limit;
   } cmd_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       end_of_frame;
      logic       last;
   } word_type;

endpackage : swpf_pkg
`default_nettype wire

// ----- hw/rtl/swpf_framer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swpf_framer
// holds the current command and builds its frames one byte per advance
// ----------------------------------------------------------------------------
module swpf_framer (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  swpf_pkg::cmd_type                req_cmd,
   input  wire [swpf_pkg::LIMIT_W-1:0]      joint_cw,
   input  wire [swpf_pkg::LIMIT_W-1:0]      joint_ccw,
   input  wire                              out_ready,
   output logic                             word_load,
   output swpf_pkg::word_type               word
);
   import swpf_pkg::*;

   cmd_type    cmd_ff;
   logic       active_ff, active_in;
   logic [4:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;

   logic       accept, known_op, second;
   logic [4:0] k, last_pos;
   logic [2:0] n;
   logic [7:0] addr, cur_byte;
   logic [7:0] par [4];
   logic       is_sum, is_chk;
   logic [1:0] j;

   // byte selection
   always_comb begin
      second = ((cmd_ff.operation == OP_WHEEL) || (cmd_ff.operation == OP_GOAL))
               && (pos_ff >= FRAME1_START);
      k = second ? 5'(pos_ff - FRAME1_START) : pos_ff;
      n = 3'd4;
      addr = ADDR_LIMITS;
      last_pos = 5'd10;
      par[0] = cmd_ff.cw_limit[7:0];
      par[1] = cmd_ff.cw_limit[15:8];
      par[2] = cmd_ff.ccw_limit[7:0];
      par[3] = cmd_ff.ccw_limit[15:8];
      case (cmd_ff.operation)
         OP_LED, OP_TORQUE: begin
            n = 3'd1;
            addr = (cmd_ff.operation == OP_LED) ? ADDR_LED : ADDR_TORQUE;
            last_pos = 5'd7;
            par[0] = cmd_ff.byte_value;
         end
         OP_WHEEL: begin
            last_pos = 5'd19;
            if (second) begin
               n = 3'd2;
               addr = ADDR_SPEED;
               par[0] = cmd_ff.speed_word[7:0];
               par[1] = cmd_ff.speed_word[15:8];
            end else begin
               par[0] = 8'h00;
               par[1] = 8'h00;
               par[2] = 8'h00;
               par[3] = 8'h00;
            end
         end
         OP_GOAL: begin
            last_pos = 5'd21;
            if (second) begin
               addr = ADDR_GOAL;
               par[0] = cmd_ff.position_word[7:0];
               par[1] = cmd_ff.position_word[15:8];
               par[2] = cmd_ff.speed_word[7:0];
               par[3] = cmd_ff.speed_word[15:8];
            end else begin
               par[0] = joint_cw[7:0];
               par[1] = {6'd0, joint_cw[LIMIT_W-1:8]};
               par[2] = joint_ccw[7:0];
               par[3] = {6'd0, joint_ccw[LIMIT_W-1:8]};
            end
         end
         default: ;
      endcase

      j = 2'(k - 5'd6);
      is_sum = 1'b1;
      is_chk = 1'b0;
      case (k)
         5'd0, 5'd1: begin
            cur_byte = SYNC_BYTE;
            is_sum = 1'b0;
         end
         5'd2: cur_byte = cmd_ff.servo_id;
         5'd3: cur_byte = {5'd0, n} + LEN_OVERHEAD;
         5'd4: cur_byte = INSTR_WRITE;
         5'd5: cur_byte = addr;
         default: begin
            if (k < 5'({2'd0, n} + 5'd6)) begin
               cur_byte = par[j];
            end else begin
               cur_byte = ~sum_ff;
               is_sum = 1'b0;
               is_chk = 1'b1;
            end
         end
      endcase
   end

   // sequencing
   always_comb begin
      word_load = active_ff && out_ready;
      req_stall = active_ff && !(word_load && (pos_ff == last_pos));
      accept = req_valid && !req_stall;
      known_op = (req_cmd.operation <= OP_TORQUE);

      word.tx_byte = cur_byte;
      word.end_of_frame = is_chk;
      word.last = (pos_ff == last_pos);

      active_in = active_ff;
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (word_load) begin
         pos_in = 5'(pos_ff + 5'd1);
         if (word.last) begin
            active_in = 1'b0;
         end
         if (is_sum) begin
            sum_in = sum_ff + cur_byte;
         end else if (!is_chk) begin
            sum_in = 8'h00;
         end
      end
      if (accept) begin
         active_in = known_op;
         pos_in = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff <= 5'd0;
         sum_ff <= 8'h00;
      end else begin
         active_ff <= active_in;
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
      end
   end

endmodule : swpf_framer
`default_nettype wire

// ----- hw/rtl/swpf_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swpf_out_stage
// result register between the framer and the byte channel
// ----------------------------------------------------------------------------
module swpf_out_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  word_load,
   input  swpf_pkg::word_type   word,
   output logic                 out_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output swpf_pkg::word_type   rsp_word
);
   import swpf_pkg::*;

   logic     valid_ff, valid_in;
   word_type word_ff;

   always_comb begin
      out_ready = !valid_ff || !rsp_stall;
      valid_in = word_load ? 1'b1 : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (word_load) begin
         word_ff <= word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word = word_ff;

endmodule : swpf_out_stage
`default_nettype wire

// ----- hw/rtl/servo_write_packet_framer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// servo_write_packet_framer_unit
// turns one servo command into write-instruction frames, one byte per word
// ----------------------------------------------------------------------------
// Each accepted command is sent as one or two frames of the form FF FF, id,
// length, 03, address, little-endian parameters, inverted checksum. led and
// torque give 8 bytes, angle limits 11, wheel speed 20 and goal position 22;
// one byte leaves the result register per cycle while the receiver does not
// stall. The next command is taken in the same cycle as the final byte of the
// current one enters the result register, so back-to-back commands leave no
// gap on the bus. Commands with an unknown operation code are taken and
// produce no bytes. The joint limits are read when the goal position frames are
// built, so write them only while no command is in flight.
// ----------------------------------------------------------------------------
module servo_write_packet_framer_unit (
   input  wire         clock,
   input  wire         reset,
   // command words
   input  wire         req_valid,
   output logic        req_stall,
   input  wire [2:0]   req_operation,
   input  wire [7:0]   req_servo_id,
   input  wire [7:0]   req_byte_value,
   input  wire [15:0]  req_speed_word,
   input  wire [15:0]  req_position_word,
   input  wire [15:0]  req_cw_limit,
   input  wire [15:0]  req_ccw_limit,
   // byte words
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_end_of_frame,
   output logic        rsp_last,
   // configuration
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire [9:0]   csr_wdata
);
   import swpf_pkg::*;

   logic [LIMIT_W-1:0] joint_cw_ff;
   logic [LIMIT_W-1:0] joint_ccw_ff;
   cmd_type            req_cmd;
   word_type           word, rsp_word;
   logic               word_load, out_ready;

   // joint limits used ahead of a goal position
   always_ff @(posedge clock) begin
      if (reset) begin
         joint_cw_ff <= JOINT_CW_RESET;
         joint_ccw_ff <= JOINT_CCW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_JOINT_CW:  joint_cw_ff <= csr_wdata;
            CSR_JOINT_CCW: joint_ccw_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      req_cmd.operation = req_operation;
      req_cmd.servo_id = req_servo_id;
      req_cmd.byte_value = req_byte_value;
      req_cmd.speed_word = req_speed_word;
      req_cmd.position_word = req_position_word;
      req_cmd.cw_limit = req_cw_limit;
      req_cmd.ccw_limit = req_ccw_limit;
   end

   // command register and byte builder
   swpf_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .joint_cw  (joint_cw_ff),
      .joint_ccw (joint_ccw_ff),
      .out_ready (out_ready),
      .word_load (word_load),
      .word      (word)
   );

   // result register toward the bus
   swpf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .word_load (word_load),
      .word      (word),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_tx_byte = rsp_word.tx_byte;
   assign rsp_end_of_frame = rsp_word.end_of_frame;
   assign rsp_last = rsp_word.last;

endmodule : servo_write_packet_framer_unit
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the servo write packet framer
// ----------------------------------------------------------------------------
// A short table of directed commands comes first. It covers field extremes,
// every command, unknown codes and checksum wrap. A few rows carry their byte
// stream typed in. All other rows are checked against a bench-side frame
// builder. Random commands follow in four phases, with different joint limits
// and different amounts of sender idling and receiver stalling. Every byte
// word is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;
   import swpf_pkg::*;

   localparam int QUIET_LIMIT      = 2000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES    = 30;    // longer than one goal position command
   localparam int RANDOM_PER_PHASE = 26;

   // one stimulus row: a command plus an optional typed-in byte stream
   typedef struct packed {
      cmd_type     cmd;
      logic        typed;
      logic [4:0]  typed_len;
      logic [63:0] typed_bytes;  // first byte in the top bits
   } cmd_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_operation;
   logic [7:0]  req_servo_id;
   logic [7:0]  req_byte_value;
   logic [15:0] req_speed_word;
   logic [15:0] req_position_word;
   logic [15:0] req_cw_limit;
   logic [15:0] req_ccw_limit;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_end_of_frame;
   logic        rsp_last;
   logic        csr_we;
   logic        csr_index;
   logic [9:0]  csr_wdata;

   // side info that travels with the command on the input channel
   logic        row_typed;
   logic [4:0]  row_typed_len;
   logic [63:0] row_typed_bytes;

   // bench copy of the joint limit registers
   logic [9:0]  joint_cw_copy  = JOINT_CW_RESET;
   logic [9:0]  joint_ccw_copy = JOINT_CCW_RESET;

   word_type    bytes_due[$];
   cmd_row_type directed_rows[$];
   int          n_errors      = 0;
   int          quiet_cycles  = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;

   servo_write_packet_framer_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_servo_id      (req_servo_id),
      .req_byte_value    (req_byte_value),
      .req_speed_word    (req_speed_word),
      .req_position_word (req_position_word),
      .req_cw_limit      (req_cw_limit),
      .req_ccw_limit     (req_ccw_limit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_end_of_frame  (rsp_end_of_frame),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver back-pressure, independent of rsp_valid
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic log_error(input string msg);
      if (n_errors < 10) $display("%0t: %s", $time, msg);
      n_errors++;
   endtask

   function automatic word_type byte_word(input logic [7:0] b, input logic eof,
                                          input logic fin);
      return {b, eof, fin};
   endfunction

   // one write frame: sync, id, length, instruction, address, params, checksum
   // params go out from the low byte up
   task automatic emit_frame(input logic [7:0] id, input logic [7:0] addr,
                             input logic [31:0] params, input int unsigned n_par,
                             input logic closes);
      logic [7:0]  sum;
      logic [7:0]  len;
      logic [7:0]  b;
      int unsigned k;
      len = 8'(n_par) + LEN_OVERHEAD;
      sum = id + len + INSTR_WRITE + addr;
      bytes_due.push_back(byte_word(SYNC_BYTE, 1'b0, 1'b0));
      bytes_due.push_back(byte_word(SYNC_BYTE, 1'b0, 1'b0));
      bytes_due.push_back(byte_word(id, 1'b0, 1'b0));
      bytes_due.push_back(byte_word(len, 1'b0, 1'b0));
      bytes_due.push_back(byte_word(INSTR_WRITE, 1'b0, 1'b0));
      bytes_due.push_back(byte_word(addr, 1'b0, 1'b0));
      for (k = 0; k < n_par; k++) begin
         b = params[8*k +: 8];
         sum = sum + b;
         bytes_due.push_back(byte_word(b, 1'b0, 1'b0));
      end
      bytes_due.push_back(byte_word(~sum, 1'b1, closes));
   endtask

   // expected byte stream of one accepted command
   task automatic frame_command(input cmd_type c);
      case (c.operation)
         OP_LED: begin
            emit_frame(c.servo_id, ADDR_LED, {24'h0, c.byte_value}, 1, 1'b1);
         end
         OP_TORQUE: begin
            emit_frame(c.servo_id, ADDR_TORQUE, {24'h0, c.byte_value}, 1, 1'b1);
         end
         OP_LIMITS: begin
            emit_frame(c.servo_id, ADDR_LIMITS, {c.ccw_limit, c.cw_limit}, 4, 1'b1);
         end
         OP_WHEEL: begin
            // wheel mode: both limits cleared first
            emit_frame(c.servo_id, ADDR_LIMITS, 32'h0, 4, 1'b0);
            emit_frame(c.servo_id, ADDR_SPEED, {16'h0, c.speed_word}, 2, 1'b1);
         end
         OP_GOAL: begin
            // joint mode: configured limits first, then position and speed
            emit_frame(c.servo_id, ADDR_LIMITS,
                       {6'h0, joint_ccw_copy, 6'h0, joint_cw_copy}, 4, 1'b0);
            emit_frame(c.servo_id, ADDR_GOAL, {c.speed_word, c.position_word}, 4, 1'b1);
         end
         default: begin
            // unknown codes are dropped without output
         end
      endcase
   endtask

   // everything is sampled at the rising edge, before any update of that edge
   always @(posedge clock) begin : monitor
      cmd_type     c;
      word_type    got;
      word_type    want;
      int unsigned k;
      if (reset) begin
         joint_cw_copy  = JOINT_CW_RESET;
         joint_ccw_copy = JOINT_CCW_RESET;
         quiet_cycles   = quiet_cycles + 1;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (csr_we) begin
            quiet_cycles = 0;
            case (csr_index)
               CSR_JOINT_CW:  joint_cw_copy  = csr_wdata;
               CSR_JOINT_CCW: joint_ccw_copy = csr_wdata;
               default: ;
            endcase
         end
         // predict first so a same-edge byte always finds its expectation
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            c = {req_operation, req_servo_id, req_byte_value, req_speed_word,
                 req_position_word, req_cw_limit, req_ccw_limit};
            if (row_typed) begin
               for (k = 0; k < row_typed_len; k++) begin
                  bytes_due.push_back(byte_word(row_typed_bytes[63-8*k -: 8],
                                                k == row_typed_len - 1,
                                                k == row_typed_len - 1));
               end
            end else begin
               frame_command(c);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            got = {rsp_tx_byte, rsp_end_of_frame, rsp_last};
            if (bytes_due.size() == 0) begin
               log_error($sformatf("unexpected word: byte %h eof %b last %b",
                                   got.tx_byte, got.end_of_frame, got.last));
            end else begin
               want = bytes_due.pop_front();
               if (got.tx_byte != want.tx_byte || got.end_of_frame != want.end_of_frame ||
                   got.last != want.last) begin
                  log_error($sformatf({"mismatch: expected byte %h eof %b last %b, ",
                                       "got byte %h eof %b last %b"},
                                      want.tx_byte, want.end_of_frame, want.last,
                                      got.tx_byte, got.end_of_frame, got.last));
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic add_row(input logic [2:0] op, input logic [7:0] id,
                          input logic [7:0] bv, input logic [15:0] spd,
                          input logic [15:0] pos, input logic [15:0] cw,
                          input logic [15:0] ccw, input logic typed,
                          input logic [4:0] len, input logic [63:0] bytes);
      cmd_row_type r;
      r.cmd         = {op, id, bv, spd, pos, cw, ccw};
      r.typed       = typed;
      r.typed_len   = len;
      r.typed_bytes = bytes;
      directed_rows.push_back(r);
   endtask

   // hold the command until it is taken; valid stays high into the next
   // command unless the sender decides to idle
   task automatic put_cmd(input cmd_row_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= r.cmd.operation;
      req_servo_id      <= r.cmd.servo_id;
      req_byte_value    <= r.cmd.byte_value;
      req_speed_word    <= r.cmd.speed_word;
      req_position_word <= r.cmd.position_word;
      req_cw_limit      <= r.cmd.cw_limit;
      req_ccw_limit     <= r.cmd.ccw_limit;
      row_typed         <= r.typed;
      row_typed_len     <= r.typed_len;
      row_typed_bytes   <= r.typed_bytes;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // called at the edge that took the last command: stop sending, then let
   // the byte stream and any dropped command settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_joint_limits(input logic [9:0] cw, input logic [9:0] ccw);
      csr_we    <= 1'b1;
      csr_index <= CSR_JOINT_CW;
      csr_wdata <= cw;
      @(posedge clock);
      csr_index <= CSR_JOINT_CCW;
      csr_wdata <= ccw;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic cmd_row_type random_row();
      cmd_row_type r;
      // a few unknown codes mixed in as noise
      if ($urandom_range(99) < 8) r.cmd.operation = 3'($urandom_range(5, 7));
      else r.cmd.operation = 3'($urandom_range(0, 4));
      r.cmd.servo_id      = 8'($urandom);
      r.cmd.byte_value    = 8'($urandom);
      r.cmd.speed_word    = 16'($urandom);
      r.cmd.position_word = 16'($urandom);
      r.cmd.cw_limit      = 16'($urandom);
      r.cmd.ccw_limit     = 16'($urandom);
      r.typed       = 1'b0;
      r.typed_len   = '0;
      r.typed_bytes = '0;
      return r;
   endfunction

   initial begin : stimulus
      int          idx;
      int          p;
      int          sent;
      cmd_row_type r;
      logic [9:0]  cw_plan [4];
      logic [9:0]  ccw_plan [4];
      int          idle_plan [4];
      int          stall_plan [4];

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = '0;
      req_servo_id      = '0;
      req_byte_value    = '0;
      req_speed_word    = '0;
      req_position_word = '0;
      req_cw_limit      = '0;
      req_ccw_limit     = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_JOINT_CW;
      csr_wdata         = '0;
      row_typed         = 1'b0;
      row_typed_len     = '0;
      row_typed_bytes   = '0;

      cw_plan    = '{10'd1023, 10'd0, 10'h155, 10'd0};
      ccw_plan   = '{10'd0, 10'd0, 10'h2AA, 10'd1023};
      idle_plan  = '{0, 48, 0, 37};
      stall_plan = '{0, 0, 48, 37};
      cw_plan[1]  = 10'($urandom_range(0, 1023));
      ccw_plan[1] = 10'($urandom_range(0, 1023));

      // directed rows; typed streams are short single frames
      add_row(OP_LED, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              1'b1, 5'd8, 64'hFFFF_0004_0319_00DF);
      // checksum wraps past 0xFF, unused fields all ones
      add_row(OP_LED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              1'b1, 5'd8, 64'hFFFF_FF04_0319_FFE1);
      add_row(OP_TORQUE, 8'h01, 8'h01, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              1'b1, 5'd8, 64'hFFFF_0104_0318_01DE);
      add_row(OP_TORQUE, 8'hFF, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              1'b1, 5'd8, 64'hFFFF_FF04_0318_00E1);
      // unknown codes give no bytes at all
      add_row(3'd5, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              1'b1, 5'd0, 64'h0);
      add_row(OP_LIMITS, 8'h01, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              1'b0, 5'd0, 64'h0);
      add_row(OP_LIMITS, 8'hFE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              1'b0, 5'd0, 64'h0);
      add_row(OP_LIMITS, 8'h5A, 8'h12, 16'h0000, 16'h0000, 16'h1234, 16'hABCD,
              1'b0, 5'd0, 64'h0);
      add_row(OP_LIMITS, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
              1'b0, 5'd0, 64'h0);
      add_row(OP_WHEEL, 8'h01, 8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              1'b0, 5'd0, 64'h0);
      add_row(OP_WHEEL, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
              1'b0, 5'd0, 64'h0);
      add_row(OP_WHEEL, 8'h33, 8'h00, 16'h8001, 16'h0000, 16'h0000, 16'h0000,
              1'b0, 5'd0, 64'h0);
      // goal position with the limits still at their reset values
      add_row(OP_GOAL, 8'h01, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
              1'b0, 5'd0, 64'h0);
      add_row(OP_GOAL, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
              1'b0, 5'd0, 64'h0);
      add_row(OP_GOAL, 8'h7E, 8'h00, 16'h0200, 16'h03FF, 16'h0000, 16'h0000,
              1'b0, 5'd0, 64'h0);
      add_row(3'd6, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              1'b1, 5'd0, 64'h0);
      add_row(OP_LED, 8'h80, 8'h7F, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              1'b0, 5'd0, 64'h0);
      add_row(3'd7, 8'hA5, 8'h5A, 16'hA5A5, 16'h5A5A, 16'hA5A5, 16'h5A5A,
              1'b1, 5'd0, 64'h0);
      add_row(OP_TORQUE, 8'h7F, 8'h80, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              1'b0, 5'd0, 64'h0);
      // goal position straight after a torque command
      add_row(OP_GOAL, 8'h10, 8'h00, 16'h0001, 16'h8000, 16'h0000, 16'h0000,
              1'b0, 5'd0, 64'h0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part back to back, no idling on either side
      for (idx = 0; idx < directed_rows.size(); idx++) begin
         put_cmd(directed_rows[idx]);
      end
      drain();

      // random phases, each with its own limits and idling mix
      for (p = 0; p < 4; p++) begin
         set_joint_limits(cw_plan[p], ccw_plan[p]);
         send_idle_pct = idle_plan[p];
         stall_pct     = stall_plan[p];
         sent = 0;
         while (sent < RANDOM_PER_PHASE) begin
            r = random_row();
            put_cmd(r);
            if (r.cmd.operation <= OP_TORQUE) sent++;
         end
         drain();
      end

      if (bytes_due.size() != 0) begin
         log_error($sformatf("%0d expected words never arrived", bytes_due.size()));
      end
      if (n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
